/* rtl/core/slx_pkg.sv */
// Shared types, token kind codes, scanner modes and byte classifiers
// for the source lexer. No dependencies.
package slx_pkg;

    // Result queue and item shape
    localparam int RES_MAX    = 4;
    localparam int FIFO_DEPTH = 8;

    // Token kinds
    localparam logic [6:0] K_END        = 7'd0;
    localparam logic [6:0] K_UNKNOWN    = 7'd1;
    localparam logic [6:0] K_IDENT      = 7'd2;
    localparam logic [6:0] K_UNDERSCORE = 7'd3;
    localparam logic [6:0] K_INT        = 7'd4;
    localparam logic [6:0] K_FLOAT      = 7'd5;
    localparam logic [6:0] K_STRING     = 7'd6;
    localparam logic [6:0] K_CHAR       = 7'd7;
    localparam logic [6:0] K_ISTART     = 7'd8;
    localparam logic [6:0] K_IMID       = 7'd9;
    localparam logic [6:0] K_IEND       = 7'd10;
    localparam logic [6:0] K_KEYWORD0   = 7'd11;
    localparam logic [6:0] K_SINGLE0    = 7'd34;
    localparam logic [6:0] K_PAIR0      = 7'd57;
    localparam logic [6:0] K_DOTDOT     = 7'd75;

    // Record types
    localparam logic REC_TEXT  = 1'b0;
    localparam logic REC_TOKEN = 1'b1;

    // Default parameter values
    localparam int KEYWORD_BYTES_DEF = 8;
    localparam int POSITION_BITS_DEF = 16;
    localparam int DEPTH_BITS_DEF    = 8;

    typedef enum logic [4:0] {
        M_IDLE, M_OP, M_LINE, M_BLOCK, M_BLOCK_STAR, M_ZERO, M_DEC, M_DEC_DOT,
        M_DEC_EXP, M_HEX, M_BIN, M_IDENT, M_STR, M_STR_ESC, M_ISTR, M_ISTR_ESC,
        M_CHR, M_CHR_ESC, M_CHR_CLOSE
    } mode_t;

    typedef struct packed {
        logic        rtype;
        logic [7:0]  text;
        logic [6:0]  kind;
        logic [15:0] line;
        logic [15:0] col;
        logic        last;
    } rec_t;

    // Keyword text, right aligned, first character in the highest used byte
    localparam logic [63:0] KW_TEXT [23] = '{
        64'("if"), 64'("else"), 64'("elseif"), 64'("for"), 64'("while"),
        64'("return"), 64'("break"), 64'("continue"), 64'("match"), 64'("struct"),
        64'("true"), 64'("false"), 64'("this"), 64'("in"), 64'("void"), 64'("int"),
        64'("float"), 64'("bool"), 64'("char"), 64'("string"), 64'("array"),
        64'("slice"), 64'("map")
    };
    localparam logic [3:0] KW_LEN [23] = '{
        4'd2, 4'd4, 4'd6, 4'd3, 4'd5, 4'd6, 4'd5, 4'd8, 4'd5, 4'd6, 4'd4, 4'd5,
        4'd4, 4'd2, 4'd4, 4'd3, 4'd5, 4'd4, 4'd4, 4'd6, 4'd5, 4'd5, 4'd3
    };

    function automatic logic is_digit(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function automatic logic is_xdigit(input logic [7:0] b);
        return is_digit(b) || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return b == " " || (b >= 8'd9 && b <= 8'd13);
    endfunction

    function automatic logic [7:0] unescape(input logic [7:0] b);
        logic [7:0] r;
        case (b)
            "n":     r = 8'd10;
            "t":     r = 8'd9;
            "0":     r = 8'd0;
            default: r = b;
        endcase
        return r;
    endfunction

    function automatic logic [6:0] single_kind(input logic [7:0] b);
        logic [6:0] k;
        case (b)
            "+":     k = K_SINGLE0 + 7'd0;
            "-":     k = K_SINGLE0 + 7'd1;
            "*":     k = K_SINGLE0 + 7'd2;
            "/":     k = K_SINGLE0 + 7'd3;
            "%":     k = K_SINGLE0 + 7'd4;
            "=":     k = K_SINGLE0 + 7'd5;
            "!":     k = K_SINGLE0 + 7'd6;
            "<":     k = K_SINGLE0 + 7'd7;
            ">":     k = K_SINGLE0 + 7'd8;
            "&":     k = K_SINGLE0 + 7'd9;
            "|":     k = K_SINGLE0 + 7'd10;
            "^":     k = K_SINGLE0 + 7'd11;
            "~":     k = K_SINGLE0 + 7'd12;
            "(":     k = K_SINGLE0 + 7'd13;
            ")":     k = K_SINGLE0 + 7'd14;
            "{":     k = K_SINGLE0 + 7'd15;
            "}":     k = K_SINGLE0 + 7'd16;
            "[":     k = K_SINGLE0 + 7'd17;
            "]":     k = K_SINGLE0 + 7'd18;
            ";":     k = K_SINGLE0 + 7'd19;
            ":":     k = K_SINGLE0 + 7'd20;
            ",":     k = K_SINGLE0 + 7'd21;
            ".":     k = K_SINGLE0 + 7'd22;
            default: k = K_UNKNOWN;
        endcase
        return k;
    endfunction

    function automatic logic opens_pair(input logic [7:0] b);
        return b == "=" || b == "!" || b == "<" || b == ">" || b == "+" || b == "-" ||
               b == "*" || b == "/" || b == "%" || b == "&" || b == "|" || b == "^" ||
               b == ":" || b == ".";
    endfunction

    // Two-byte operator kind, or K_END when the pair is no operator
    function automatic logic [6:0] pair_kind(input logic [7:0] h, input logic [7:0] b);
        logic [6:0] k;
        k = K_END;
        case (h)
            "=": if (b == "=") k = K_PAIR0 + 7'd0;
                 else if (b == ">") k = K_PAIR0 + 7'd1;
            "!": if (b == "=") k = K_PAIR0 + 7'd2;
            "<": if (b == "=") k = K_PAIR0 + 7'd3;
                 else if (b == "<") k = K_PAIR0 + 7'd4;
            ">": if (b == "=") k = K_PAIR0 + 7'd5;
                 else if (b == ">") k = K_PAIR0 + 7'd6;
            "+": if (b == "+") k = K_PAIR0 + 7'd7;
                 else if (b == "=") k = K_PAIR0 + 7'd8;
            "-": if (b == "-") k = K_PAIR0 + 7'd9;
                 else if (b == "=") k = K_PAIR0 + 7'd10;
            "*": if (b == "=") k = K_PAIR0 + 7'd11;
            "/": if (b == "=") k = K_PAIR0 + 7'd12;
            "%": if (b == "=") k = K_PAIR0 + 7'd13;
            "&": if (b == "&") k = K_PAIR0 + 7'd14;
            "|": if (b == "|") k = K_PAIR0 + 7'd15;
            "^": if (b == "^") k = K_PAIR0 + 7'd16;
            ":": if (b == "=") k = K_PAIR0 + 7'd17;
            ".": if (b == ".") k = K_PAIR0 + 7'd18;
            default: k = K_END;
        endcase
        return k;
    endfunction

    // Keyword lookup over the first eight stored bytes (byte 0 lowest)
    function automatic logic [6:0] kw_kind(input logic [63:0] w, input logic [3:0] len);
        logic [6:0] k;
        logic       hit;
        k = K_IDENT;
        for (int n = 22; n >= 0; n--) begin
            hit = (KW_LEN[n] == len);
            for (int i = 0; i < 8; i++) begin
                if (i < int'(KW_LEN[n]) &&
                    w[i*8 +: 8] != KW_TEXT[n][(int'(KW_LEN[n]) - 1 - i)*8 +: 8])
                begin
                    hit = 1'b0;
                end
            end
            if (hit)
            begin
                k = K_KEYWORD0 + 7'(n);
            end
        end
        return k;
    endfunction

    function automatic rec_t mk_text(input logic [7:0] b);
        rec_t r;
        r       = '0;
        r.rtype = REC_TEXT;
        r.text  = b;
        return r;
    endfunction

endpackage

/* rtl/core/slx_scan.sv */
// Scanner state and per-byte next-state logic of the source lexer.
// Produces up to four result items per accepted byte. Uses slx_pkg.
module slx_scan #(
    parameter int KEYWORD_BYTES = slx_pkg::KEYWORD_BYTES_DEF,
    parameter int POSITION_BITS = slx_pkg::POSITION_BITS_DEF,
    parameter int DEPTH_BITS    = slx_pkg::DEPTH_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  take,
    input  logic [7:0]                            char_byte,
    input  logic                                  end_of_source,
    output slx_pkg::rec_t [slx_pkg::RES_MAX-1:0]  res,
    output logic [2:0]                            res_count
);
    import slx_pkg::*;

    localparam int WL_BITS = $clog2(KEYWORD_BYTES + 2);

    mode_t                         mode_reg, mode_next;
    logic [7:0]                    held_reg, held_next;
    logic [KEYWORD_BYTES-1:0][7:0] wbuf_reg, wbuf_next;
    logic [WL_BITS-1:0]            wlen_reg, wlen_next;
    logic                          flt_reg, flt_next;
    logic                          iact_reg, iact_next;
    logic [DEPTH_BITS-1:0]         idep_reg, idep_next;
    logic [POSITION_BITS-1:0]      line_reg, line_next, col_reg, col_next;
    logic [POSITION_BITS-1:0]      tl_reg, tl_next, tc_reg, tc_next;
    logic [POSITION_BITS-1:0]      dl_reg, dl_next, dc_reg, dc_next;

    rec_t [RES_MAX-1:0] r;
    logic [2:0]         n;
    logic               eos, dec_go, idle_go;
    logic [7:0]         b;

    function automatic logic [15:0] sat(input logic [POSITION_BITS-1:0] v);
        logic [POSITION_BITS+15:0] wide;
        wide = {16'd0, v};
        if ((wide >> 16) != '0)
        begin
            return 16'hFFFF;
        end
        return wide[15:0];
    endfunction

    function automatic rec_t mk_tok(input logic [6:0] k,
                                    input logic [POSITION_BITS-1:0] ln,
                                    input logic [POSITION_BITS-1:0] cl);
        rec_t t;
        t       = '0;
        t.rtype = REC_TOKEN;
        t.kind  = k;
        t.line  = sat(ln);
        t.col   = sat(cl);
        return t;
    endfunction

    function automatic logic [6:0] ident_kind(input logic [KEYWORD_BYTES-1:0][7:0] w,
                                              input logic [WL_BITS-1:0] len);
        if (len == WL_BITS'(1) && w[0] == "_")
        begin
            return K_UNDERSCORE;
        end
        if (len > WL_BITS'(8))
        begin
            return K_IDENT;
        end
        return kw_kind(w[7:0], 4'(len));
    endfunction

    // Next state and results for one byte
    always_comb
    begin
        mode_next = mode_reg;  held_next = held_reg;  wbuf_next = wbuf_reg;
        wlen_next = wlen_reg;  flt_next = flt_reg;    iact_next = iact_reg;
        idep_next = idep_reg;  line_next = line_reg;  col_next = col_reg;
        tl_next = tl_reg;      tc_next = tc_reg;      dl_next = dl_reg;
        dc_next = dc_reg;
        r = '0;
        n = 3'd0;
        dec_go  = 1'b0;
        idle_go = 1'b0;
        b   = char_byte;
        eos = end_of_source || (char_byte == 8'd0);

        if (eos)
        begin
            // flush pending token, then the end token, then back to reset
            case (mode_reg)
                M_OP:
                begin
                    r[n[1:0]] = mk_text(held_reg); n = n + 3'd1;
                    r[n[1:0]] = mk_tok(single_kind(held_reg), tl_reg, tc_reg); n = n + 3'd1;
                end
                M_DEC_DOT:
                begin
                    r[n[1:0]] = mk_text("."); n = n + 3'd1;
                    r[n[1:0]] = mk_tok(K_FLOAT, tl_reg, tc_reg); n = n + 3'd1;
                end
                M_ZERO, M_DEC, M_DEC_EXP:
                begin
                    r[n[1:0]] = mk_tok(flt_reg ? K_FLOAT : K_INT, tl_reg, tc_reg);
                    n = n + 3'd1;
                end
                M_HEX, M_BIN:
                begin
                    r[n[1:0]] = mk_tok(K_INT, tl_reg, tc_reg); n = n + 3'd1;
                end
                M_IDENT:
                begin
                    r[n[1:0]] = mk_tok(ident_kind(wbuf_reg, wlen_reg), tl_reg, tc_reg);
                    n = n + 3'd1;
                end
                M_STR, M_STR_ESC:
                begin
                    r[n[1:0]] = mk_tok(K_STRING, tl_reg, tc_reg); n = n + 3'd1;
                end
                M_ISTR, M_ISTR_ESC:
                begin
                    r[n[1:0]] = mk_tok(K_IEND, tl_reg, tc_reg); n = n + 3'd1;
                end
                M_CHR, M_CHR_ESC, M_CHR_CLOSE:
                begin
                    r[n[1:0]] = mk_tok(K_CHAR, tl_reg, tc_reg); n = n + 3'd1;
                end
                default: ;
            endcase
            r[n[1:0]] = mk_tok(K_END, line_reg, col_reg); n = n + 3'd1;
            mode_next = M_IDLE;  held_next = '0;  wbuf_next = '0;  wlen_next = '0;
            flt_next = 1'b0;  iact_next = 1'b0;  idep_next = '0;
            line_next = POSITION_BITS'(1);  col_next = POSITION_BITS'(1);
            tl_next = POSITION_BITS'(1);    tc_next = POSITION_BITS'(1);
            dl_next = POSITION_BITS'(1);    dc_next = POSITION_BITS'(1);
        end
        else
        begin
            // mode specific handling
            case (mode_reg)
                M_OP:
                begin
                    if (held_reg == "/" && b == "/")
                    begin
                        mode_next = M_LINE;
                    end
                    else if (held_reg == "/" && b == "*")
                    begin
                        mode_next = M_BLOCK;
                    end
                    else if (pair_kind(held_reg, b) != K_END)
                    begin
                        r[n[1:0]] = mk_text(held_reg); n = n + 3'd1;
                        r[n[1:0]] = mk_text(b); n = n + 3'd1;
                        r[n[1:0]] = mk_tok(pair_kind(held_reg, b), tl_next, tc_next);
                        n = n + 3'd1;
                        mode_next = M_IDLE;
                    end
                    else
                    begin
                        r[n[1:0]] = mk_text(held_reg); n = n + 3'd1;
                        r[n[1:0]] = mk_tok(single_kind(held_reg), tl_next, tc_next);
                        n = n + 3'd1;
                        idle_go = 1'b1;
                    end
                end
                M_LINE:
                begin
                    if (b == 8'd10) mode_next = M_IDLE;
                end
                M_BLOCK:
                begin
                    if (b == "*") mode_next = M_BLOCK_STAR;
                end
                M_BLOCK_STAR:
                begin
                    if (b == "/") mode_next = M_IDLE;
                    else if (b != "*") mode_next = M_BLOCK;
                end
                M_ZERO:
                begin
                    if (b == "x")
                    begin
                        r[n[1:0]] = mk_text(b); n = n + 3'd1; mode_next = M_HEX;
                    end
                    else if (b == "b")
                    begin
                        r[n[1:0]] = mk_text(b); n = n + 3'd1; mode_next = M_BIN;
                    end
                    else dec_go = 1'b1;
                end
                M_DEC: dec_go = 1'b1;
                M_DEC_DOT:
                begin
                    if (b == ".")
                    begin
                        r[n[1:0]] = mk_tok(K_INT, tl_next, tc_next); n = n + 3'd1;
                        tl_next = dl_reg;
                        tc_next = dc_reg;
                        r[n[1:0]] = mk_text("."); n = n + 3'd1;
                        r[n[1:0]] = mk_text("."); n = n + 3'd1;
                        r[n[1:0]] = mk_tok(K_DOTDOT, tl_next, tc_next); n = n + 3'd1;
                        mode_next = M_IDLE;
                    end
                    else
                    begin
                        r[n[1:0]] = mk_text("."); n = n + 3'd1;
                        flt_next = 1'b1;
                        dec_go = 1'b1;
                    end
                end
                M_DEC_EXP:
                begin
                    if (b == "+" || b == "-")
                    begin
                        r[n[1:0]] = mk_text(b); n = n + 3'd1; mode_next = M_DEC;
                    end
                    else dec_go = 1'b1;
                end
                M_HEX, M_BIN:
                begin
                    if ((mode_reg == M_HEX) ? is_xdigit(b) : (b == "0" || b == "1"))
                    begin
                        r[n[1:0]] = mk_text(b); n = n + 3'd1;
                    end
                    else
                    begin
                        r[n[1:0]] = mk_tok(K_INT, tl_next, tc_next); n = n + 3'd1;
                        idle_go = 1'b1;
                    end
                end
                M_IDENT:
                begin
                    if (is_alpha(b) || is_digit(b) || b == "_")
                    begin
                        for (int i = 0; i < KEYWORD_BYTES; i++)
                        begin
                            if (wlen_next == WL_BITS'(i)) wbuf_next[i] = b;
                        end
                        if (wlen_next <= WL_BITS'(KEYWORD_BYTES))
                        begin
                            wlen_next = wlen_next + WL_BITS'(1);
                        end
                        r[n[1:0]] = mk_text(b); n = n + 3'd1;
                    end
                    else
                    begin
                        r[n[1:0]] = mk_tok(ident_kind(wbuf_reg, wlen_reg), tl_next, tc_next);
                        n = n + 3'd1;
                        idle_go = 1'b1;
                    end
                end
                M_STR, M_ISTR:
                begin
                    if (b == "\"")
                    begin
                        r[n[1:0]] = mk_tok((mode_reg == M_ISTR) ? K_IEND : K_STRING,
                                           tl_next, tc_next);
                        n = n + 3'd1;
                        if (mode_reg == M_ISTR) iact_next = 1'b0;
                        mode_next = M_IDLE;
                    end
                    else if (b == "\\")
                    begin
                        mode_next = (mode_reg == M_ISTR) ? M_ISTR_ESC : M_STR_ESC;
                    end
                    else if (b == "{")
                    begin
                        r[n[1:0]] = mk_tok((mode_reg == M_ISTR) ? K_IMID : K_ISTART,
                                           tl_next, tc_next);
                        n = n + 3'd1;
                        iact_next = 1'b1;
                        idep_next = '0;
                        mode_next = M_IDLE;
                    end
                    else
                    begin
                        r[n[1:0]] = mk_text(b); n = n + 3'd1;
                    end
                end
                M_STR_ESC:
                begin
                    r[n[1:0]] = mk_text(unescape(b)); n = n + 3'd1; mode_next = M_STR;
                end
                M_ISTR_ESC:
                begin
                    r[n[1:0]] = mk_text(unescape(b)); n = n + 3'd1; mode_next = M_ISTR;
                end
                M_CHR:
                begin
                    if (b == "\\") mode_next = M_CHR_ESC;
                    else
                    begin
                        r[n[1:0]] = mk_text(b); n = n + 3'd1; mode_next = M_CHR_CLOSE;
                    end
                end
                M_CHR_ESC:
                begin
                    r[n[1:0]] = mk_text(unescape(b)); n = n + 3'd1;
                    mode_next = M_CHR_CLOSE;
                end
                M_CHR_CLOSE:
                begin
                    r[n[1:0]] = mk_tok(K_CHAR, tl_next, tc_next); n = n + 3'd1;
                    if (b == "'") mode_next = M_IDLE;
                    else idle_go = 1'b1;
                end
                default: idle_go = 1'b1;
            endcase

            // decimal number body
            if (dec_go)
            begin
                if (is_digit(b))
                begin
                    r[n[1:0]] = mk_text(b); n = n + 3'd1; mode_next = M_DEC;
                end
                else if (b == "." && !flt_next)
                begin
                    dl_next = line_reg;
                    dc_next = col_reg;
                    mode_next = M_DEC_DOT;
                end
                else if (b == "e" || b == "E")
                begin
                    r[n[1:0]] = mk_text(b); n = n + 3'd1;
                    flt_next = 1'b1;
                    mode_next = M_DEC_EXP;
                end
                else
                begin
                    r[n[1:0]] = mk_tok(flt_next ? K_FLOAT : K_INT, tl_next, tc_next);
                    n = n + 3'd1;
                    idle_go = 1'b1;
                end
            end

            // byte seen between tokens
            if (idle_go)
            begin
                mode_next = M_IDLE;
                if (!is_space(b))
                begin
                    tl_next = line_reg;
                    tc_next = col_reg;
                    if (iact_next && b == "}" && idep_next == '0)
                    begin
                        mode_next = M_ISTR;
                    end
                    else
                    begin
                        if (iact_next && b == "}")
                        begin
                            idep_next = idep_next - DEPTH_BITS'(1);
                        end
                        else if (iact_next && b == "{" && idep_next != '1)
                        begin
                            idep_next = idep_next + DEPTH_BITS'(1);
                        end
                        if (b == "\"")
                        begin
                            mode_next = M_STR;
                        end
                        else if (b == "'")
                        begin
                            mode_next = M_CHR;
                        end
                        else if (is_digit(b))
                        begin
                            r[n[1:0]] = mk_text(b); n = n + 3'd1;
                            flt_next = 1'b0;
                            mode_next = (b == "0") ? M_ZERO : M_DEC;
                        end
                        else if (is_alpha(b) || b == "_")
                        begin
                            wbuf_next[0] = b;
                            wlen_next = WL_BITS'(1);
                            r[n[1:0]] = mk_text(b); n = n + 3'd1;
                            mode_next = M_IDENT;
                        end
                        else if (opens_pair(b))
                        begin
                            held_next = b;
                            mode_next = M_OP;
                        end
                        else
                        begin
                            r[n[1:0]] = mk_text(b); n = n + 3'd1;
                            r[n[1:0]] = mk_tok(single_kind(b), tl_next, tc_next);
                            n = n + 3'd1;
                        end
                    end
                end
            end

            // position counters
            if (b == 8'd10)
            begin
                if (line_reg != '1) line_next = line_reg + POSITION_BITS'(1);
                col_next = POSITION_BITS'(1);
            end
            else if (col_reg != '1)
            begin
                col_next = col_reg + POSITION_BITS'(1);
            end
        end

        // mark the final result of this byte
        if (n != 3'd0)
        begin
            r[2'(n - 3'd1)].last = 1'b1;
        end
    end

    assign res       = r;
    assign res_count = take ? n : 3'd0;

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_IDLE;  held_reg <= '0;  wbuf_reg <= '0;  wlen_reg <= '0;
            flt_reg <= 1'b0;  iact_reg <= 1'b0;  idep_reg <= '0;
            line_reg <= POSITION_BITS'(1);  col_reg <= POSITION_BITS'(1);
            tl_reg <= POSITION_BITS'(1);    tc_reg <= POSITION_BITS'(1);
            dl_reg <= POSITION_BITS'(1);    dc_reg <= POSITION_BITS'(1);
        end
        else if (take)
        begin
            mode_reg <= mode_next;  held_reg <= held_next;  wbuf_reg <= wbuf_next;
            wlen_reg <= wlen_next;  flt_reg <= flt_next;    iact_reg <= iact_next;
            idep_reg <= idep_next;  line_reg <= line_next;  col_reg <= col_next;
            tl_reg <= tl_next;      tc_reg <= tc_next;      dl_reg <= dl_next;
            dc_reg <= dc_next;
        end
    end

endmodule

/* rtl/core/slx_queue.sv */
// Result item queue: takes up to four items per cycle, hands out one
// while rd_ready is high. Uses slx_pkg.
module slx_queue (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  slx_pkg::rec_t [slx_pkg::RES_MAX-1:0]  wr_data,
    input  logic [2:0]                            wr_count,
    output logic                                  room,
    output logic                                  rd_valid,
    input  logic                                  rd_ready,
    output slx_pkg::rec_t                         rd_data
);
    import slx_pkg::*;

    localparam int PW = $clog2(FIFO_DEPTH);

    rec_t          mem [FIFO_DEPTH];
    logic [PW-1:0] wp_reg, wp_next, rp_reg, rp_next;
    logic [PW:0]   cnt_reg, cnt_next;
    logic          pop;

    assign pop      = rd_valid && rd_ready;
    assign rd_valid = cnt_reg != '0;
    assign room     = cnt_reg <= (PW + 1)'(FIFO_DEPTH - RES_MAX);
    assign rd_data  = mem[rp_reg];

    // pointer and fill updates
    always_comb
    begin
        wp_next  = wp_reg + PW'(wr_count);
        rp_next  = pop ? rp_reg + PW'(1) : rp_reg;
        cnt_next = cnt_reg + (PW + 1)'(wr_count) - (PW + 1)'(pop);
    end

    // storage
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < RES_MAX; i++)
        begin
            if (3'(i) < wr_count) mem[PW'(wp_reg + PW'(i))] <= wr_data[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

/* rtl/core/source_lexer_with_interpolation.sv */
// Top level of the streaming source lexer with string interpolation.
// Depends on slx_pkg, slx_scan and slx_queue.
//
// One source byte is taken per cycle whenever the result queue has room for four items;
// each byte updates the scanner state in the cycle it is accepted and yields zero to
// four result items, which leave the eight-entry queue at one item per ready cycle. The
// sustained input rate is therefore one byte per cycle while the average result count
// stays at or below one per byte, and is set by the single output port otherwise.
// Decoded text bytes come out before their token record; a zero byte or tlast ends the
// source, emits the end token and returns the scanner to its reset state.
module source_lexer_with_interpolation #(
    parameter int KEYWORD_BYTES = slx_pkg::KEYWORD_BYTES_DEF,
    parameter int POSITION_BITS = slx_pkg::POSITION_BITS_DEF,
    parameter int DEPTH_BITS    = slx_pkg::DEPTH_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // char_byte
    input  logic        s_tlast,   // end_of_source
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // text_byte, token_kind, start_line, start_column, pad
    output logic        m_tuser,   // record_type
    output logic        m_tlast    // last_of_run
);
    import slx_pkg::*;

    rec_t [RES_MAX-1:0] res;
    logic [2:0]         res_count;
    logic               take;
    rec_t               head;

    assign take = s_tvalid && s_tready;

    // per-byte scanner
    slx_scan #(
        .KEYWORD_BYTES (KEYWORD_BYTES),
        .POSITION_BITS (POSITION_BITS),
        .DEPTH_BITS    (DEPTH_BITS)
    ) u_scan (
        .clk           (clk),
        .rst_n         (rst_n),
        .take          (take),
        .char_byte     (s_tdata),
        .end_of_source (s_tlast),
        .res           (res),
        .res_count     (res_count)
    );

    // result queue
    slx_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_data  (res),
        .wr_count (res_count),
        .room     (s_tready),
        .rd_valid (m_tvalid),
        .rd_ready (m_tready),
        .rd_data  (head)
    );

    // output packing
    assign m_tdata = {1'b0, head.col, head.line, head.kind, head.text};
    assign m_tuser = head.rtype;
    assign m_tlast = head.last;

endmodule

/* test/tb_source_lexer_with_interpolation.sv */
// Self-checking testbench for source_lexer_with_interpolation: drives source bytes,
// predicts text and token items in a behavioral scanner and checks every result item.
// Depends on slx_pkg and the lexer RTL.
`timescale 1ns / 1ps

module tb_source_lexer_with_interpolation;
    import slx_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;   // char_byte
    logic        s_tlast = 1'b0;   // end_of_source
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;          // text_byte, token_kind, start_line, start_column, pad
    logic        m_tuser;          // record_type
    logic        m_tlast;          // last_of_run

    source_lexer_with_interpolation uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    always #10 clk = ~clk;

    // Lexer tables
    string kw_words [23] = '{"if", "else", "elseif", "for", "while", "return", "break",
        "continue", "match", "struct", "true", "false", "this", "in", "void", "int",
        "float", "bool", "char", "string", "array", "slice", "map"};
    string single_chars = "+-*/%=!<>&|^~(){}[];:,.";
    string pair_list [19] = '{"==", "=>", "!=", "<=", "<<", ">=", ">>", "++", "+=", "--",
        "-=", "*=", "/=", "%=", "&&", "||", "^^", ":=", ".."};

    // Scanner state mirrored by the predictor
    mode_t      scan_st;
    logic [7:0] held_ch;
    logic [7:0] word_bytes [8];
    int         word_len;
    bit         num_float;
    bit         in_interp;
    int         brace_depth;
    int         cur_line, cur_col, tok_line, tok_col, dot_line, dot_col, at_line, at_col;

    rec_t step_recs [$];
    rec_t expected_recs [$];
    int   fail_count = 0;
    int   bytes_sent = 0;
    int   recs_checked = 0;
    bit   tx_calm = 0;
    bit   rx_calm = 0;
    int   rx_hold = 0;

    function automatic bit ch_digit(logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction
    function automatic bit ch_alpha(logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction
    function automatic bit ch_hex(logic [7:0] b);
        return ch_digit(b) || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
    endfunction
    function automatic bit ch_blank(logic [7:0] b);
        return b == " " || (b >= 8'd9 && b <= 8'd13);
    endfunction
    function automatic logic [7:0] esc_value(logic [7:0] b);
        if (b == "n") return 8'd10;
        if (b == "t") return 8'd9;
        if (b == "0") return 8'd0;
        return b;
    endfunction
    function automatic logic [6:0] op_kind(logic [7:0] b);
        for (int i = 0; i < 23; i++)
            if (single_chars[i] == b) return K_SINGLE0 + 7'(i);
        return K_UNKNOWN;
    endfunction
    function automatic bit pair_head(logic [7:0] b);
        for (int i = 0; i < 19; i++)
            if (pair_list[i][0] == b) return 1'b1;
        return 1'b0;
    endfunction
    function automatic logic [15:0] clip16(int v);
        return (v > 65535) ? 16'hFFFF : 16'(v);
    endfunction

    task lex_reset();
        scan_st = M_IDLE;
        held_ch = 8'd0;
        foreach (word_bytes[i]) word_bytes[i] = 8'd0;
        word_len = 0;
        num_float = 0;
        in_interp = 0;
        brace_depth = 0;
        cur_line = 1; cur_col = 1; tok_line = 1; tok_col = 1; dot_line = 1; dot_col = 1;
    endtask

    task put_text(logic [7:0] b);
        rec_t r;
        r = '0;
        r.rtype = REC_TEXT;
        r.text = b;
        step_recs.insert(step_recs.size(), r);
    endtask

    task put_token(logic [6:0] k, int ln, int cl);
        rec_t r;
        r = '0;
        r.rtype = REC_TOKEN;
        r.kind = k;
        r.line = clip16(ln);
        r.col = clip16(cl);
        step_recs.insert(step_recs.size(), r);
    endtask

    task word_add(logic [7:0] b);
        if (word_len < 8) word_bytes[word_len] = b;
        if (word_len <= 8) word_len++;
    endtask

    task ident_done();
        bit hit;
        scan_st = M_IDLE;
        if (word_len == 1 && word_bytes[0] == "_")
        begin
            put_token(K_UNDERSCORE, tok_line, tok_col);
            return;
        end
        for (int i = 0; i < 23; i++)
        begin
            hit = (kw_words[i].len() == word_len);
            for (int j = 0; j < kw_words[i].len() && hit; j++)
                if (word_bytes[j] != kw_words[i][j]) hit = 0;
            if (hit)
            begin
                put_token(K_KEYWORD0 + 7'(i), tok_line, tok_col);
                return;
            end
        end
        put_token(K_IDENT, tok_line, tok_col);
    endtask

    task number_done();
        put_token(num_float ? K_FLOAT : K_INT, tok_line, tok_col);
        scan_st = M_IDLE;
    endtask

    // Byte seen between tokens
    task idle_ch(logic [7:0] b);
        scan_st = M_IDLE;
        if (ch_blank(b)) return;
        tok_line = at_line;
        tok_col = at_col;
        if (in_interp && b == "}")
        begin
            if (brace_depth == 0)
            begin
                scan_st = M_ISTR;
                return;
            end
            brace_depth--;
        end
        else if (in_interp && b == "{")
        begin
            if (brace_depth < 255) brace_depth++;
        end
        if (b == "\"")
        begin
            scan_st = M_STR;
            return;
        end
        if (b == "'")
        begin
            scan_st = M_CHR;
            return;
        end
        if (ch_digit(b))
        begin
            put_text(b);
            num_float = 0;
            scan_st = (b == "0") ? M_ZERO : M_DEC;
            return;
        end
        if (ch_alpha(b) || b == "_")
        begin
            word_len = 0;
            word_add(b);
            put_text(b);
            scan_st = M_IDENT;
            return;
        end
        if (pair_head(b))
        begin
            held_ch = b;
            scan_st = M_OP;
            return;
        end
        put_text(b);
        put_token(op_kind(b), tok_line, tok_col);
    endtask

    task dec_ch(logic [7:0] b);
        if (ch_digit(b))
        begin
            put_text(b);
            scan_st = M_DEC;
        end
        else if (b == ".")
        begin
            if (num_float)
            begin
                number_done();
                idle_ch(b);
            end
            else
            begin
                dot_line = at_line;
                dot_col = at_col;
                scan_st = M_DEC_DOT;
            end
        end
        else if (b == "e" || b == "E")
        begin
            put_text(b);
            num_float = 1;
            scan_st = M_DEC_EXP;
        end
        else
        begin
            number_done();
            idle_ch(b);
        end
    endtask

    task op_ch(logic [7:0] b);
        if (held_ch == "/" && b == "/")
        begin
            scan_st = M_LINE;
            return;
        end
        if (held_ch == "/" && b == "*")
        begin
            scan_st = M_BLOCK;
            return;
        end
        for (int i = 0; i < 19; i++)
        begin
            if (pair_list[i][0] == held_ch && pair_list[i][1] == b)
            begin
                put_text(held_ch);
                put_text(b);
                put_token(K_PAIR0 + 7'(i), tok_line, tok_col);
                scan_st = M_IDLE;
                return;
            end
        end
        put_text(held_ch);
        put_token(op_kind(held_ch), tok_line, tok_col);
        idle_ch(b);
    endtask

    task str_ch(logic [7:0] b, bit cont);
        if (b == "\"")
        begin
            put_token(cont ? K_IEND : K_STRING, tok_line, tok_col);
            if (cont) in_interp = 0;
            scan_st = M_IDLE;
        end
        else if (b == "\\")
        begin
            scan_st = cont ? M_ISTR_ESC : M_STR_ESC;
        end
        else if (b == "{")
        begin
            put_token(cont ? K_IMID : K_ISTART, tok_line, tok_col);
            in_interp = 1;
            brace_depth = 0;
            scan_st = M_IDLE;
        end
        else
        begin
            put_text(b);
        end
    endtask

    task scan_ch(logic [7:0] b);
        case (scan_st)
            M_OP: op_ch(b);
            M_LINE: if (b == 8'd10) scan_st = M_IDLE;
            M_BLOCK: if (b == "*") scan_st = M_BLOCK_STAR;
            M_BLOCK_STAR:
                if (b == "/") scan_st = M_IDLE;
                else if (b != "*") scan_st = M_BLOCK;
            M_ZERO:
                if (b == "x")
                begin
                    put_text(b);
                    scan_st = M_HEX;
                end
                else if (b == "b")
                begin
                    put_text(b);
                    scan_st = M_BIN;
                end
                else dec_ch(b);
            M_DEC: dec_ch(b);
            M_DEC_DOT:
                if (b == ".")
                begin
                    put_token(K_INT, tok_line, tok_col);
                    tok_line = dot_line;
                    tok_col = dot_col;
                    put_text(".");
                    put_text(".");
                    put_token(K_DOTDOT, tok_line, tok_col);
                    scan_st = M_IDLE;
                end
                else
                begin
                    put_text(".");
                    num_float = 1;
                    dec_ch(b);
                end
            M_DEC_EXP:
                if (b == "+" || b == "-")
                begin
                    put_text(b);
                    scan_st = M_DEC;
                end
                else dec_ch(b);
            M_HEX, M_BIN:
                if (scan_st == M_HEX ? ch_hex(b) : (b == "0" || b == "1")) put_text(b);
                else
                begin
                    put_token(K_INT, tok_line, tok_col);
                    idle_ch(b);
                end
            M_IDENT:
                if (ch_alpha(b) || ch_digit(b) || b == "_")
                begin
                    word_add(b);
                    put_text(b);
                end
                else
                begin
                    ident_done();
                    idle_ch(b);
                end
            M_STR: str_ch(b, 1'b0);
            M_ISTR: str_ch(b, 1'b1);
            M_STR_ESC:
            begin
                put_text(esc_value(b));
                scan_st = M_STR;
            end
            M_ISTR_ESC:
            begin
                put_text(esc_value(b));
                scan_st = M_ISTR;
            end
            M_CHR:
                if (b == "\\") scan_st = M_CHR_ESC;
                else
                begin
                    put_text(b);
                    scan_st = M_CHR_CLOSE;
                end
            M_CHR_ESC:
            begin
                put_text(esc_value(b));
                scan_st = M_CHR_CLOSE;
            end
            M_CHR_CLOSE:
            begin
                put_token(K_CHAR, tok_line, tok_col);
                if (b == "'") scan_st = M_IDLE;
                else idle_ch(b);
            end
            default: idle_ch(b);
        endcase
    endtask

    // End of source: flush the pending token, then the end token
    task flush_source();
        case (scan_st)
            M_OP:
            begin
                put_text(held_ch);
                put_token(op_kind(held_ch), tok_line, tok_col);
            end
            M_DEC_DOT:
            begin
                put_text(".");
                put_token(K_FLOAT, tok_line, tok_col);
            end
            M_ZERO, M_DEC, M_DEC_EXP: number_done();
            M_HEX, M_BIN: put_token(K_INT, tok_line, tok_col);
            M_IDENT: ident_done();
            M_STR, M_STR_ESC: put_token(K_STRING, tok_line, tok_col);
            M_ISTR, M_ISTR_ESC: put_token(K_IEND, tok_line, tok_col);
            M_CHR, M_CHR_ESC, M_CHR_CLOSE: put_token(K_CHAR, tok_line, tok_col);
            default: ;
        endcase
        put_token(K_END, cur_line, cur_col);
    endtask

    // Expected items for one accepted byte
    task lex_step(logic [7:0] b, bit eos);
        step_recs.delete();
        if (eos || b == 8'd0)
        begin
            flush_source();
            lex_reset();
        end
        else
        begin
            at_line = cur_line;
            at_col = cur_col;
            scan_ch(b);
            if (b == 8'd10)
            begin
                if (cur_line < 65535) cur_line++;
                cur_col = 1;
            end
            else if (cur_col < 65535)
            begin
                cur_col++;
            end
        end
        if (step_recs.size() > 0) step_recs[step_recs.size() - 1].last = 1'b1;
        foreach (step_recs[i]) expected_recs.insert(expected_recs.size(), step_recs[i]);
    endtask

    function automatic int pick_gap();
        if ($urandom_range(0, 19) == 0) return $urandom_range(8, 30);
        return $urandom_range(0, 2);
    endfunction

    // Send one item and predict its results when accepted
    task send_byte(logic [7:0] b, bit eos);
        int gap;
        gap = tx_calm ? 0 : ($urandom_range(0, 2) == 0 ? pick_gap() : 0);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= eos;
        do @(posedge clk); while (!s_tready);
        lex_step(b, eos);
        bytes_sent++;
        if ($urandom_range(0, 49) == 0) tx_calm = ~tx_calm;
    endtask

    task send_text(string src);
        for (int i = 0; i < src.len(); i++) send_byte(src[i], 1'b0);
    endtask

    task end_source();
        send_byte(8'($urandom), 1'b1);
    endtask

    // Result side: random stalls and comparison against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        rec_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_recs.size() == 0)
                begin
                    $error("unexpected item: tuser=%0b tdata=%h", m_tuser, m_tdata);
                    fail_count++;
                end
                else
                begin
                    want = expected_recs.pop_front();
                    recs_checked++;
                    if (m_tuser !== want.rtype)
                    begin
                        $error("record_type: expected %0d, got %0d", want.rtype, m_tuser);
                        fail_count++;
                    end
                    if (m_tdata[7:0] !== want.text)
                    begin
                        $error("text_byte: expected %0d, got %0d", want.text, m_tdata[7:0]);
                        fail_count++;
                    end
                    if (m_tdata[14:8] !== want.kind)
                    begin
                        $error("token_kind: expected %0d, got %0d", want.kind, m_tdata[14:8]);
                        fail_count++;
                    end
                    if (m_tdata[30:15] !== want.line)
                    begin
                        $error("start_line: expected %0d, got %0d", want.line, m_tdata[30:15]);
                        fail_count++;
                    end
                    if (m_tdata[46:31] !== want.col)
                    begin
                        $error("start_column: expected %0d, got %0d", want.col,
                               m_tdata[46:31]);
                        fail_count++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $error("last_of_run: expected %0d, got %0d", want.last, m_tlast);
                        fail_count++;
                    end
                end
            end
            if (rx_hold > 0)
            begin
                rx_hold <= rx_hold - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!rx_calm && $urandom_range(0, 3) == 0) rx_hold <= pick_gap();
            end
            if ($urandom_range(0, 99) == 0) rx_calm <= ~rx_calm;
        end
    end

    // Directed tests
    task test_words();
        send_text("elseif continue _ abcdefghij\n");
        end_source();
    endtask

    task test_numbers();
        send_text("0x1Fg 0b12 1..2 1.5e+3 2.3.4 1.");
        end_source();
    endtask

    task test_operators();
        send_text("a<<=b:=c=>//x\n/* **/%~");
        send_byte(8'hC8, 1'b0);
        send_byte(8'h00, 1'b0);
    endtask

    task test_literals();
        send_text("\"a\\n\\\"{x\"{1}\\t}\" '\\0' ''' 'ab \"s{");
        end_source();
        send_text("\"u\\");
        end_source();
        send_text("'\\");
        end_source();
    endtask

    // Nested braces inside interpolation and back to the string
    task test_brace_depth();
        send_text("\"{{}}z\"");
        end_source();
    endtask

    // Random source built mostly from well-formed tokens with random content
    function automatic string rand_ident();
        string s;
        int n;
        n = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 5);
        s = "";
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 3))
                0: s = {s, string'(8'($urandom_range("a", "z")))};
                1: s = {s, string'(8'($urandom_range("A", "Z")))};
                2: s = {s, (i == 0) ? "_" : string'(8'($urandom_range("0", "9")))};
                default: s = {s, "_"};
            endcase
        end
        return s;
    endfunction

    function automatic string rand_piece();
        case ($urandom_range(0, 11))
            0: return kw_words[$urandom_range(0, 22)];
            1: return rand_ident();
            2: return $sformatf("%0d", $urandom_range(0, 999));
            3: return $sformatf("0x%h", 16'($urandom));
            4: return $sformatf("0b%b", 4'($urandom));
            5: return $sformatf("%0d.%0de%s%0d", $urandom_range(0, 9), $urandom_range(0, 99),
                                $urandom_range(0, 1) ? "-" : "+", $urandom_range(0, 9));
            6: return pair_list[$urandom_range(0, 18)];
            7: return string'(single_chars[$urandom_range(0, 22)]);
            8: return {"\"", rand_ident(), "{", rand_ident(), "}\\n",
                       $urandom_range(0, 1) ? "{1}" : "", "\""};
            9: return {"'", string'(8'($urandom_range(32, 126))), "'"};
            10: return $urandom_range(0, 1) ? "// c\n" : "/* ** */";
            default: return $urandom_range(0, 1) ? "\n" : "\t";
        endcase
    endfunction

    task test_random_source();
        int start;
        logic [7:0] b;
        start = bytes_sent;
        while (bytes_sent - start < 10)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                b = 8'($urandom);
                send_byte(b, ($urandom_range(0, 15) == 0));
            end
            else
            begin
                send_text(rand_piece());
                send_byte(" ", 1'b0);
            end
        end
        end_source();
    endtask

    initial
    begin
        int waited;
        lex_reset();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_words();
        test_numbers();
        test_operators();
        test_literals();
        test_brace_depth();
        test_random_source();
        s_tvalid <= 1'b0;
        s_tlast <= 1'b0;
        waited = 0;
        while (expected_recs.size() > 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (20) @(posedge clk);
        if (expected_recs.size() > 0) fail_count++;
        $display("Sent %0d source bytes, checked %0d result items", bytes_sent, recs_checked);
        $display("(keywords, numbers, operators, comments, literals, interpolation braces)");
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Run limit
    initial
    begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/slx_pkg.sv
rtl/core/slx_scan.sv
rtl/core/slx_queue.sv
rtl/core/source_lexer_with_interpolation.sv
test/tb_source_lexer_with_interpolation.sv
